### rtl/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg: shared types and constants for the bilinear image scaler
// Word layouts, field widths, register indexes and clamp helpers.
// ----------------------------------------------------------------------------
package bis_pkg;

    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned NUM_LANES       = 4;
    localparam int unsigned PIXEL_W         = BYTE_W * NUM_LANES;
    localparam int unsigned SRC_DIM_W       = 9;
    localparam int unsigned TGT_DIM_W       = 13;
    localparam int unsigned COORD_W         = 12;
    localparam int unsigned STORE_W         = 8;
    localparam int unsigned NCH_W           = 3;
    localparam int unsigned CFG_IDX_W       = 3;
    localparam int unsigned CFG_DATA_W      = 16;
    localparam int unsigned PROD_W          = COORD_W + SRC_DIM_W;
    localparam int unsigned WEIGHT_W        = 2 * COORD_W;
    localparam int unsigned SUM_W           = WEIGHT_W + BYTE_W + 2;
    localparam int unsigned MIN_TARGET      = 2;
    localparam int unsigned MAX_TARGET      = 4096;
    localparam int unsigned MAX_SRC_DEF     = 256;
    localparam int unsigned SRC_RESET       = 256;
    localparam int unsigned TGT_RESET       = 256;
    localparam int unsigned NCH_RESET       = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_WIDTH  = 3'd0,
        CFG_SOURCE_HEIGHT = 3'd1,
        CFG_TARGET_WIDTH  = 3'd2,
        CFG_TARGET_HEIGHT = 3'd3,
        CFG_CHANNEL_COUNT = 3'd4
    } t_cfg_index;

    typedef enum logic {
        OP_STORE   = 1'b0,
        OP_REQUEST = 1'b1
    } t_operation;

    typedef struct packed {
        logic                 operation;
        logic [STORE_W-1:0]   store_column;
        logic [STORE_W-1:0]   store_row;
        logic [PIXEL_W-1:0]   store_pixel;
        logic [COORD_W-1:0]   target_column;
        logic [COORD_W-1:0]   target_row;
    } t_in_word;

    typedef struct packed {
        logic [PIXEL_W-1:0]   result_pixel;
        logic [COORD_W-1:0]   result_column;
        logic [COORD_W-1:0]   result_row;
    } t_out_word;

    // target size saturated to 2..4096, returned minus one
    function automatic logic [COORD_W-1:0] tgt_minus_one(input logic [TGT_DIM_W-1:0] v);
        logic [COORD_W-1:0] r;
        if (v < TGT_DIM_W'(MIN_TARGET)) begin
            r = COORD_W'(MIN_TARGET - 1);
        end else if (v > TGT_DIM_W'(MAX_TARGET)) begin
            r = COORD_W'(MAX_TARGET - 1);
        end else begin
            r = COORD_W'(v - TGT_DIM_W'(1));
        end
        return r;
    endfunction

    function automatic logic [NCH_W-1:0] nch_clamp(input logic [NCH_W-1:0] v);
        logic [NCH_W-1:0] r;
        if (v == '0) begin
            r = NCH_W'(1);
        end else if (v > NCH_W'(NUM_LANES)) begin
            r = NCH_W'(NUM_LANES);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

### rtl/bis_div.sv
// ----------------------------------------------------------------------------
// bis_div: pipelined restoring divider
// One quotient bit per stage; quotient must fit in Q_W bits.
// ----------------------------------------------------------------------------
module bis_div #(
    parameter int unsigned NUM_W = 21,
    parameter int unsigned DEN_W = 12,
    parameter int unsigned Q_W   = 9
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [Q_W-1:0]   o_quo,
    output logic [DEN_W-1:0] o_rem
);
    localparam int unsigned WW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [WW-1:0]    p_rem [Q_W+1];
    logic [DEN_W-1:0] p_den [Q_W+1];
    logic [Q_W-1:0]   p_quo [Q_W+1];

    assign p_rem[0] = WW'(i_num);
    assign p_den[0] = i_den;
    assign p_quo[0] = '0;

    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        localparam int unsigned B = Q_W - 1 - s;
        logic [WW-1:0]    n_sub;
        logic [WW-1:0]    r_rem;
        logic [DEN_W-1:0] r_den;
        logic [Q_W-1:0]   r_quo;

        assign n_sub = WW'(p_den[s]) << B;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den <= p_den[s];
                if (p_rem[s] >= n_sub) begin
                    r_rem <= p_rem[s] - n_sub;
                    r_quo <= p_quo[s] | (Q_W'(1) << B);
                end else begin
                    r_rem <= p_rem[s];
                    r_quo <= p_quo[s];
                end
            end
        end

        assign p_rem[s+1] = r_rem;
        assign p_den[s+1] = r_den;
        assign p_quo[s+1] = r_quo;
    end

    assign o_quo = p_quo[Q_W];
    assign o_rem = p_rem[Q_W][DEN_W-1:0];

endmodule

### rtl/bis_bank.sv
// ----------------------------------------------------------------------------
// bis_bank: one parity bank of the source frame store
// Single port: write on store words, registered read otherwise.
// ----------------------------------------------------------------------------
module bis_bank
    import bis_pkg::*;
#(
    parameter int unsigned AW = 14
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic               i_we,
    input  logic [AW-1:0]      i_addr,
    input  logic [PIXEL_W-1:0] i_wdata,
    output logic [PIXEL_W-1:0] o_rdata
);
    logic [PIXEL_W-1:0] r_mem [2**AW];
    logic [PIXEL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/bis_lane.sv
// ----------------------------------------------------------------------------
// bis_lane: one channel of the bilinear blend
// Weighted products, rounded sum, then division by the weight total.
// ----------------------------------------------------------------------------
module bis_lane
    import bis_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [BYTE_W-1:0]   i_a,
    input  logic [BYTE_W-1:0]   i_b,
    input  logic [BYTE_W-1:0]   i_c,
    input  logic [BYTE_W-1:0]   i_d,
    input  logic [WEIGHT_W-1:0] i_wa,
    input  logic [WEIGHT_W-1:0] i_wb,
    input  logic [WEIGHT_W-1:0] i_wc,
    input  logic [WEIGHT_W-1:0] i_wd,
    input  logic [WEIGHT_W-1:0] i_den,
    output logic [BYTE_W-1:0]   o_byte
);
    localparam int unsigned PW = BYTE_W + WEIGHT_W;

    logic [PW-1:0]    r_pa, r_pb, r_pc, r_pd;
    logic [SUM_W-1:0] r_sum;
    logic [WEIGHT_W-1:0] w_rem;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pa  <= PW'(i_a) * PW'(i_wa);
            r_pb  <= PW'(i_b) * PW'(i_wb);
            r_pc  <= PW'(i_c) * PW'(i_wc);
            r_pd  <= PW'(i_d) * PW'(i_wd);
            // add half the divisor to round
            r_sum <= SUM_W'(r_pa) + SUM_W'(r_pb) + SUM_W'(r_pc) + SUM_W'(r_pd)
                   + SUM_W'(i_den >> 1);
        end
    end

    bis_div #(
        .NUM_W (SUM_W),
        .DEN_W (WEIGHT_W),
        .Q_W   (BYTE_W)
    ) u_div (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r_sum),
        .i_den (i_den),
        .o_quo (o_byte),
        .o_rem (w_rem)
    );

    logic w_unused;
    assign w_unused = ^w_rem;

endmodule

### rtl/bilinear_image_scaler_top.sv
// Throughput: one word per cycle, stores and requests alike, while the output is not stalled;
// a full pipeline stall holds every stage while the output word waits.
// The frame store is four parity banks, so the four neighbors are read in the same cycle.
// Reset (synchronous, active low) clears valid bits and sets the registers to
// 256 x 256 source, 256 x 256 target, 3 channels; the frame store is not cleared.
// ----------------------------------------------------------------------------
// bilinear_image_scaler_top: integer bilinear image scaler
// Stores source pixels in a banked frame store and returns rounded blends.
// ----------------------------------------------------------------------------
module bilinear_image_scaler_top
    import bis_pkg::*;
#(
    parameter int unsigned MAX_SOURCE_WIDTH  = MAX_SRC_DEF,
    parameter int unsigned MAX_SOURCE_HEIGHT = MAX_SRC_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int unsigned COLS = (MAX_SOURCE_WIDTH < 256) ? MAX_SOURCE_WIDTH : 256;
    localparam int unsigned ROWS = (MAX_SOURCE_HEIGHT < 256) ? MAX_SOURCE_HEIGHT : 256;
    localparam int unsigned XI = ($clog2(COLS) > 1) ? $clog2(COLS) - 1 : 1;
    localparam int unsigned YI = ($clog2(ROWS) > 1) ? $clog2(ROWS) - 1 : 1;
    localparam int unsigned AW = XI + YI;
    localparam int unsigned XQ_W = SRC_DIM_W;
    localparam int unsigned DIV_LAT = XQ_W;
    localparam int unsigned LANE_LAT = BYTE_W + 2;
    localparam int unsigned SW_RST =
        ((SRC_RESET < MAX_SOURCE_WIDTH) ? SRC_RESET : MAX_SOURCE_WIDTH) - 1;
    localparam int unsigned SH_RST =
        ((SRC_RESET < MAX_SOURCE_HEIGHT) ? SRC_RESET : MAX_SOURCE_HEIGHT) - 1;

    logic w_en;

    // ---------------- configuration ----------------
    logic [SRC_DIM_W-1:0] r_sw, r_sh;
    logic [COORD_W-1:0]   r_dw, r_dh;
    logic [NCH_W-1:0]     r_nch;
    logic [WEIGHT_W-1:0]  r_den;
    logic [SRC_DIM_W-1:0] w_src_v;

    assign o_cfg_ready = 1'b1;
    assign w_src_v     = i_cfg_data[SRC_DIM_W-1:0];

    function automatic logic [SRC_DIM_W-1:0] src_minus_one(
        input logic [SRC_DIM_W-1:0] v,
        input int unsigned          lim
    );
        logic [SRC_DIM_W-1:0] r;
        if (v == '0) begin
            r = '0;
        end else if (int'(v) > lim) begin
            r = SRC_DIM_W'(lim - 1);
        end else begin
            r = v - SRC_DIM_W'(1);
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw  <= SRC_DIM_W'(SW_RST);
            r_sh  <= SRC_DIM_W'(SH_RST);
            r_dw  <= COORD_W'(TGT_RESET - 1);
            r_dh  <= COORD_W'(TGT_RESET - 1);
            r_nch <= NCH_W'(NCH_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_SOURCE_WIDTH:  r_sw  <= src_minus_one(w_src_v, MAX_SOURCE_WIDTH);
                CFG_SOURCE_HEIGHT: r_sh  <= src_minus_one(w_src_v, MAX_SOURCE_HEIGHT);
                CFG_TARGET_WIDTH:  r_dw  <= tgt_minus_one(i_cfg_data[TGT_DIM_W-1:0]);
                CFG_TARGET_HEIGHT: r_dh  <= tgt_minus_one(i_cfg_data[TGT_DIM_W-1:0]);
                CFG_CHANNEL_COUNT: r_nch <= nch_clamp(i_cfg_data[NCH_W-1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_den <= WEIGHT_W'(r_dw) * WEIGHT_W'(r_dh);
    end

    // ---------------- stage 0: input register ----------------
    logic      r_s0_vld;
    t_in_word  r_s0;

    logic      r_out_vld;
    t_out_word r_out;

    assign w_en       = !r_out_vld || i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (w_en) begin
            r_s0_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0 <= i_in_data;
        end
    end

    // ---------------- stage 1: scaled positions ----------------
    logic [COORD_W-1:0] w_j, w_i;
    logic               r_s1_vld;
    t_in_word           r_s1;
    logic [PROD_W-1:0]  r_s1_pj, r_s1_pi;

    // saturate requests beyond the target to its last pixel
    assign w_j = (r_s0.target_column > r_dw) ? r_dw : r_s0.target_column;
    assign w_i = (r_s0.target_row > r_dh) ? r_dh : r_s0.target_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= r_s0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1    <= r_s0;
            r_s1_pj <= PROD_W'(w_j) * PROD_W'(r_sw);
            r_s1_pi <= PROD_W'(w_i) * PROD_W'(r_sh);
        end
    end

    // ---------------- coordinate division ----------------
    logic [XQ_W-1:0]    w_x, w_y;
    logic [COORD_W-1:0] w_rx, w_ry;
    logic               r_d_vld [DIV_LAT];
    t_in_word           r_d     [DIV_LAT];

    bis_div #(.NUM_W(PROD_W), .DEN_W(COORD_W), .Q_W(XQ_W)) u_div_x (
        .i_clk (i_clk), .i_en (w_en), .i_num (r_s1_pj), .i_den (r_dw),
        .o_quo (w_x), .o_rem (w_rx)
    );

    bis_div #(.NUM_W(PROD_W), .DEN_W(COORD_W), .Q_W(XQ_W)) u_div_y (
        .i_clk (i_clk), .i_en (w_en), .i_num (r_s1_pi), .i_den (r_dh),
        .o_quo (w_y), .o_rem (w_ry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_LAT; s++) begin
                r_d_vld[s] <= 1'b0;
            end
        end else if (w_en) begin
            r_d_vld[0] <= r_s1_vld;
            for (int s = 1; s < DIV_LAT; s++) begin
                r_d_vld[s] <= r_d_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d[0] <= r_s1;
            for (int s = 1; s < DIV_LAT; s++) begin
                r_d[s] <= r_d[s-1];
            end
        end
    end

    // ---------------- stage C: weights and bank addresses ----------------
    t_in_word             w_dc;
    logic [XQ_W-1:0]      w_xb, w_yn;
    logic [COORD_W-1:0]   w_bw, w_nw;
    logic [SRC_DIM_W-1:0] w_scol, w_srow;
    logic                 w_store_ok;

    assign w_dc   = r_d[DIV_LAT-1];
    assign w_bw   = r_dw - w_rx;
    assign w_nw   = r_dh - w_ry;
    // repeat the neighbor when the position lands exactly on a source pixel
    assign w_xb   = (w_rx == '0) ? w_x : w_x + XQ_W'(1);
    assign w_yn   = (w_ry == '0) ? w_y : w_y + XQ_W'(1);
    assign w_scol = SRC_DIM_W'(w_dc.store_column);
    assign w_srow = SRC_DIM_W'(w_dc.store_row);
    assign w_store_ok = (int'(w_scol) < MAX_SOURCE_WIDTH)
                     && (int'(w_srow) < MAX_SOURCE_HEIGHT);

    logic                 r_c_vld;
    logic                 r_c_req;
    logic [AW-1:0]        r_c_addr [NUM_LANES];
    logic                 r_c_we   [NUM_LANES];
    logic [PIXEL_W-1:0]   r_c_wdata;
    logic [1:0]           r_c_sel  [NUM_LANES];
    logic [WEIGHT_W-1:0]  r_c_w    [NUM_LANES];
    logic [COORD_W-1:0]   r_c_col, r_c_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_en) begin
            r_c_vld <= r_d_vld[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_req   <= (w_dc.operation == OP_REQUEST);
            r_c_wdata <= w_dc.store_pixel;
            r_c_col   <= w_dc.target_column;
            r_c_row   <= w_dc.target_row;
            r_c_sel[0] <= {w_y[0], w_x[0]};
            r_c_sel[1] <= {w_y[0], w_xb[0]};
            r_c_sel[2] <= {w_yn[0], w_x[0]};
            r_c_sel[3] <= {w_yn[0], w_xb[0]};
            r_c_w[0]  <= WEIGHT_W'(w_bw) * WEIGHT_W'(w_nw);
            r_c_w[1]  <= WEIGHT_W'(w_rx) * WEIGHT_W'(w_nw);
            r_c_w[2]  <= WEIGHT_W'(w_bw) * WEIGHT_W'(w_ry);
            r_c_w[3]  <= WEIGHT_W'(w_rx) * WEIGHT_W'(w_ry);
            for (int p = 0; p < NUM_LANES; p++) begin
                if (w_dc.operation == OP_STORE) begin
                    r_c_addr[p] <= {w_srow[YI:1], w_scol[XI:1]};
                    r_c_we[p]   <= r_d_vld[DIV_LAT-1] && w_store_ok
                                && (p[0] == w_scol[0]) && (p[1] == w_srow[0]);
                end else begin
                    r_c_we[p] <= 1'b0;
                    r_c_addr[p] <= {((w_y[0] == p[1]) ? w_y[YI:1] : w_yn[YI:1]),
                                    ((w_x[0] == p[0]) ? w_x[XI:1] : w_xb[XI:1])};
                end
            end
        end
    end

    // ---------------- stage M: parity banks ----------------
    logic [PIXEL_W-1:0] w_rd [NUM_LANES];

    for (genvar p = 0; p < NUM_LANES; p++) begin : g_bank
        bis_bank #(.AW(AW)) u_bank (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_we    (r_c_we[p]),
            .i_addr  (r_c_addr[p]),
            .i_wdata (r_c_wdata),
            .o_rdata (w_rd[p])
        );
    end

    logic                r_m_vld;
    logic [1:0]          r_m_sel [NUM_LANES];
    logic [WEIGHT_W-1:0] r_m_w   [NUM_LANES];
    logic [COORD_W-1:0]  r_m_col, r_m_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (w_en) begin
            // drop store words here; only requests produce results
            r_m_vld <= r_c_vld && r_c_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_sel <= r_c_sel;
            r_m_w   <= r_c_w;
            r_m_col <= r_c_col;
            r_m_row <= r_c_row;
        end
    end

    // ---------------- channel lanes ----------------
    logic [BYTE_W-1:0] w_byte [NUM_LANES];

    for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
        bis_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_a    (w_rd[r_m_sel[0]][k*BYTE_W +: BYTE_W]),
            .i_b    (w_rd[r_m_sel[1]][k*BYTE_W +: BYTE_W]),
            .i_c    (w_rd[r_m_sel[2]][k*BYTE_W +: BYTE_W]),
            .i_d    (w_rd[r_m_sel[3]][k*BYTE_W +: BYTE_W]),
            .i_wa   (r_m_w[0]),
            .i_wb   (r_m_w[1]),
            .i_wc   (r_m_w[2]),
            .i_wd   (r_m_w[3]),
            .i_den  (r_den),
            .o_byte (w_byte[k])
        );
    end

    logic               r_l_vld [LANE_LAT];
    logic [COORD_W-1:0] r_l_col [LANE_LAT];
    logic [COORD_W-1:0] r_l_row [LANE_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LANE_LAT; s++) begin
                r_l_vld[s] <= 1'b0;
            end
        end else if (w_en) begin
            r_l_vld[0] <= r_m_vld;
            for (int s = 1; s < LANE_LAT; s++) begin
                r_l_vld[s] <= r_l_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_l_col[0] <= r_m_col;
            r_l_row[0] <= r_m_row;
            for (int s = 1; s < LANE_LAT; s++) begin
                r_l_col[s] <= r_l_col[s-1];
                r_l_row[s] <= r_l_row[s-1];
            end
        end
    end

    // ---------------- merge and output register ----------------
    logic [PIXEL_W-1:0] w_pix;

    always_comb begin
        w_pix = '0;
        for (int k = 0; k < NUM_LANES; k++) begin
            if (NCH_W'(k) < r_nch) begin
                w_pix[k*BYTE_W +: BYTE_W] = w_byte[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_l_vld[LANE_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.result_pixel  <= w_pix;
            r_out.result_column <= r_l_col[LANE_LAT-1];
            r_out.result_row    <= r_l_row[LANE_LAT-1];
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule
